// File: rtl/mpam_pkg.sv
// ----------------------------------------------------------------------------
// Mixer package
// Shared constants, register codes, payload types and constant tables.
// ----------------------------------------------------------------------------
`default_nettype none

package mpam_pkg;

    localparam int PORT_COUNT_DEF      = 4;
    localparam int FIFO_DEPTH_DEF      = 1024;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // ports that have a volume register and mode bits
    localparam int REG_PORTS  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MASTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOL0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOL1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOL2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOL3     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODES    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd7;

    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_FIFO = 2'd1;
    localparam logic [1:0] MODE_TONE = 2'd2;

    localparam logic [15:0] UNITY_Q15      = 16'h8000;
    localparam logic [31:0] STEP_RESET     = 32'd39370534;
    localparam logic [3:0]  CHANNELS_RESET = 4'd2;
    localparam logic [3:0]  MAX_CHANNELS   = 4'd8;

    localparam logic [32:0] TWO_PI_Q30     = 33'd6746518852;
    localparam logic [31:0] TONE_AMPLITUDE = 32'd16000;
    localparam logic [2:0]  LAST_TERM      = 3'd7;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic               func;
        logic [1:0]         port_index;
        logic signed [15:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic               push_ok;
    } out_item_t;

    typedef struct packed {
        logic [15:0]                master_volume;
        logic [REG_PORTS-1:0][15:0] port_volume;
        logic [7:0]                 port_modes;
        logic [31:0]                tone_step;
        logic [3:0]                 channel_count;
    } cfg_t;

    // Taylor term divisor (2i)(2i+1)
    function automatic logic [7:0] term_divisor(input logic [2:0] i);
        logic [7:0] d;
        case (i)
            3'd1:    d = 8'd6;
            3'd2:    d = 8'd20;
            3'd3:    d = 8'd42;
            3'd4:    d = 8'd72;
            3'd5:    d = 8'd110;
            3'd6:    d = 8'd156;
            3'd7:    d = 8'd210;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] term_recip(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd1:    r = 32'd715827882;
            3'd2:    r = 32'd214748364;
            3'd3:    r = 32'd102261126;
            3'd4:    r = 32'd59652323;
            3'd5:    r = 32'd39045157;
            3'd6:    r = 32'd27531841;
            3'd7:    r = 32'd20452225;
            default: r = 32'd715827882;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mpam_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/mpam_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 33 x 32 multiply with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mpam_mul (
    input  wire logic                        aclk,
    input  wire logic [mpam_pkg::MUL_A_W-1:0] op_a,
    input  wire logic [mpam_pkg::MUL_B_W-1:0] op_b,
    output logic      [mpam_pkg::MUL_P_W-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= mpam_pkg::MUL_P_W'(op_a) * mpam_pkg::MUL_P_W'(op_b);
    end

endmodule

`default_nettype wire

// File: rtl/mpam_core.sv
// ----------------------------------------------------------------------------
// Mixer core
// Sequencer over ports: FIFO bookkeeping, sine evaluation and scaling, with every
// multiply going through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mpam_core #(
    parameter int PORT_COUNT      = mpam_pkg::PORT_COUNT_DEF,
    parameter int FIFO_DEPTH      = mpam_pkg::FIFO_DEPTH_DEF,
    parameter int SINE_TABLE_BITS = mpam_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mpam_pkg::cfg_t      cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mpam_pkg::in_item_t  in_item,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output mpam_pkg::out_item_t      res_item
);

    localparam int AW        = $clog2(FIFO_DEPTH);
    localparam int LW        = $clog2(FIFO_DEPTH + 1);
    localparam int PW        = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int CW        = $clog2(PORT_COUNT + 1);
    localparam int RAM_AW    = PW + AW;
    localparam int RAM_DEPTH = 1 << RAM_AW;
    localparam int B         = SINE_TABLE_BITS;
    localparam int KW        = SINE_TABLE_BITS - 1;
    localparam int HALF      = 1 << (SINE_TABLE_BITS - 1);
    localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
    localparam logic [LW-1:0] FULL     = LW'(FIFO_DEPTH);

    typedef enum logic [16:0] {
        ST_IDLE    = 17'b00000000000000001,
        ST_PUSH    = 17'b00000000000000010,
        ST_SEL     = 17'b00000000000000100,
        ST_FIFO_RD = 17'b00000000000001000,
        ST_SIN_X   = 17'b00000000000010000,
        ST_SIN_SQ  = 17'b00000000000100000,
        ST_SIN_T   = 17'b00000000001000000,
        ST_SIN_M   = 17'b00000000010000000,
        ST_SIN_YR  = 17'b00000000100000000,
        ST_SIN_QD  = 17'b00000001000000000,
        ST_SIN_R   = 17'b00000010000000000,
        ST_SIN_ACC = 17'b00000100000000000,
        ST_SIN_AMP = 17'b00001000000000000,
        ST_SIN_MAG = 17'b00010000000000000,
        ST_SC_P1   = 17'b00100000000000000,
        ST_SC_P2   = 17'b01000000000000000,
        ST_SC_ACC  = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    mpam_pkg::in_item_t item_reg;
    logic               done_reg;
    logic               ok_reg;

    logic [AW-1:0] wp_reg   [PORT_COUNT];
    logic [AW-1:0] rp_reg   [PORT_COUNT];
    logic [LW-1:0] fill_reg [PORT_COUNT];
    logic [31:0]   phase_reg[PORT_COUNT];
    logic [2:0]    frame_pos_reg;

    logic [CW-1:0]      cnt_reg;
    logic signed [15:0] acc_reg;
    logic [15:0]        smag_reg;
    logic               sneg_reg;
    logic               tneg_reg;
    logic [KW-1:0]      kq_reg;
    logic [31:0]        x_reg, x2_reg, term_reg, sum_reg, y_reg, q0_reg;
    logic [2:0]         i_reg;

    logic [mpam_pkg::MUL_A_W-1:0] mul_a;
    logic [mpam_pkg::MUL_B_W-1:0] mul_b;
    logic [mpam_pkg::MUL_P_W-1:0] prod_reg;

    logic              ram_we, ram_re;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_rdata;

    logic [PW-1:0] pidx, cur;
    logic          push_ok;
    logic [1:0]    mode;
    logic [15:0]   pvol, mvol;
    logic [3:0]    frame_len;
    logic [2:0]    fp_inc;
    logic          frame_end;
    logic [31:0]   xs;
    logic [B-1:0]  kfull;
    logic [B-1:0]  klow;
    logic [31:0]   rem;
    logic [16:0]   neg_rd;
    logic [45:0]   amp_sum;
    logic signed [17:0] acc_ext, mag_ext, acc_sum;
    logic signed [15:0] acc_sat;

    assign in_ready  = (state_reg == ST_IDLE) && !done_reg;
    assign res_valid = done_reg;
    assign res_item.mixed_sample = item_reg.func ? acc_reg : 16'sd0;
    assign res_item.push_ok      = ok_reg;

    assign pidx = PW'(item_reg.port_index);
    assign cur  = (state_reg == ST_PUSH) ? pidx : cnt_reg[PW-1:0];

    assign push_ok = (32'(item_reg.port_index) < 32'(PORT_COUNT)) && (fill_reg[cur] < FULL);

    always_comb begin
        if (32'(cnt_reg) < 32'(mpam_pkg::REG_PORTS)) begin
            mode = 2'(cfg.port_modes >> {cnt_reg, 1'b0});
            pvol = cfg.port_volume[2'(cnt_reg)];
        end else begin
            mode = mpam_pkg::MODE_STOP;
            pvol = 16'd0;
        end
        if (pvol > mpam_pkg::UNITY_Q15) begin
            pvol = mpam_pkg::UNITY_Q15;
        end
    end

    assign mvol = (cfg.master_volume > mpam_pkg::UNITY_Q15) ? mpam_pkg::UNITY_Q15
                                                             : cfg.master_volume;

    always_comb begin
        if (cfg.channel_count == 4'd0) begin
            frame_len = 4'd1;
        end else if (cfg.channel_count > mpam_pkg::MAX_CHANNELS) begin
            frame_len = mpam_pkg::MAX_CHANNELS;
        end else begin
            frame_len = cfg.channel_count;
        end
    end

    assign fp_inc    = frame_pos_reg + 3'd1;
    assign frame_end = (fp_inc == 3'd0) || ({1'b0, fp_inc} >= frame_len);

    assign xs      = prod_reg[B +: 32];
    assign kfull   = phase_reg[cur][31 -: B];
    assign klow    = {1'b0, kfull[B-2:0]};
    assign rem     = y_reg - prod_reg[31:0];
    assign neg_rd  = 17'd0 - {ram_rdata[15], ram_rdata};
    assign amp_sum = prod_reg[45:0] + 46'(1 << 20);

    assign acc_ext = 18'(acc_reg);
    assign mag_ext = $signed({2'b00, prod_reg[30 +: 16]});
    assign acc_sum = sneg_reg ? (acc_ext - mag_ext) : (acc_ext + mag_ext);

    always_comb begin
        if (acc_sum > 18'sd32767) begin
            acc_sat = 16'sh7FFF;
        end else if (acc_sum < -18'sd32768) begin
            acc_sat = 16'sh8000;
        end else begin
            acc_sat = acc_sum[15:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SIN_X: begin
                mul_a = mpam_pkg::TWO_PI_Q30;
                mul_b = 32'(kq_reg);
            end
            ST_SIN_SQ: begin
                mul_a = 33'(xs);
                mul_b = xs;
            end
            ST_SIN_M: begin
                mul_a = 33'(term_reg);
                mul_b = x2_reg;
            end
            ST_SIN_YR: begin
                mul_a = 33'(prod_reg[30 +: 32]);
                mul_b = mpam_pkg::term_recip(i_reg);
            end
            ST_SIN_QD: begin
                mul_a = 33'(prod_reg[32 +: 32]);
                mul_b = 32'(mpam_pkg::term_divisor(i_reg));
            end
            ST_SIN_AMP: begin
                mul_a = 33'(sum_reg);
                mul_b = mpam_pkg::TONE_AMPLITUDE;
            end
            ST_SC_P1: begin
                mul_a = 33'(smag_reg);
                mul_b = 32'(pvol);
            end
            ST_SC_P2: begin
                mul_a = 33'(prod_reg[31:0]);
                mul_b = 32'(mvol);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mpam_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .prod_reg(prod_reg)
    );

    assign ram_we    = (state_reg == ST_PUSH) && push_ok;
    assign ram_waddr = {cur, wp_reg[cur]};
    assign ram_re    = (state_reg == ST_SEL) && (cnt_reg != CW'(PORT_COUNT))
                       && (mode == mpam_pkg::MODE_FIFO) && (fill_reg[cur] != '0);
    assign ram_raddr = {cur, rp_reg[cur]};

    mpam_ram #(
        .WIDTH(16),
        .DEPTH(RAM_DEPTH)
    ) u_fifo_ram (
        .aclk     (aclk),
        .we       (ram_we),
        .waddr    (ram_waddr),
        .wdata    (item_reg.sample_in),
        .re       (ram_re),
        .raddr    (ram_raddr),
        .rdata_reg(ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    state_next = in_item.func ? ST_SEL : ST_PUSH;
                end
            end
            ST_PUSH:    state_next = ST_IDLE;
            ST_SEL: begin
                if (cnt_reg == CW'(PORT_COUNT)) begin
                    state_next = ST_IDLE;
                end else if (mode == mpam_pkg::MODE_FIFO) begin
                    state_next = (fill_reg[cur] != '0) ? ST_FIFO_RD : ST_SEL;
                end else if (mode == mpam_pkg::MODE_TONE) begin
                    state_next = ST_SIN_X;
                end
            end
            ST_FIFO_RD: state_next = ST_SC_P1;
            ST_SIN_X:   state_next = ST_SIN_SQ;
            ST_SIN_SQ:  state_next = ST_SIN_T;
            ST_SIN_T:   state_next = ST_SIN_M;
            ST_SIN_M:   state_next = ST_SIN_YR;
            ST_SIN_YR:  state_next = ST_SIN_QD;
            ST_SIN_QD:  state_next = ST_SIN_R;
            ST_SIN_R:   state_next = ST_SIN_ACC;
            ST_SIN_ACC: state_next = (i_reg == mpam_pkg::LAST_TERM) ? ST_SIN_AMP : ST_SIN_M;
            ST_SIN_AMP: state_next = ST_SIN_MAG;
            ST_SIN_MAG: state_next = ST_SC_P1;
            ST_SC_P1:   state_next = ST_SC_P2;
            ST_SC_P2:   state_next = ST_SC_ACC;
            ST_SC_ACC:  state_next = ST_SEL;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            cnt_reg       <= '0;
            frame_pos_reg <= '0;
            for (int p = 0; p < PORT_COUNT; p++) begin
                wp_reg[p]    <= '0;
                rp_reg[p]    <= '0;
                fill_reg[p]  <= '0;
                phase_reg[p] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (done_reg && res_ready) begin
                done_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid && in_ready) begin
                        cnt_reg <= '0;
                    end
                end
                ST_PUSH: begin
                    ok_reg   <= push_ok;
                    done_reg <= 1'b1;
                    if (push_ok) begin
                        wp_reg[cur]   <= (wp_reg[cur] == LAST_PTR) ? '0 : wp_reg[cur] + 1'b1;
                        fill_reg[cur] <= fill_reg[cur] + 1'b1;
                    end
                end
                ST_SEL: begin
                    if (cnt_reg == CW'(PORT_COUNT)) begin
                        // frame bookkeeping, then hand the mix out
                        ok_reg   <= 1'b0;
                        done_reg <= 1'b1;
                        if (frame_end) begin
                            frame_pos_reg <= '0;
                            for (int p = 0; p < PORT_COUNT; p++) begin
                                if (p < mpam_pkg::REG_PORTS) begin
                                    if (cfg.port_modes[2*p +: 2] == mpam_pkg::MODE_TONE) begin
                                        phase_reg[p] <= phase_reg[p] + cfg.tone_step;
                                    end
                                end
                            end
                        end else begin
                            frame_pos_reg <= fp_inc;
                        end
                    end else if (mode == mpam_pkg::MODE_FIFO) begin
                        if (fill_reg[cur] != '0) begin
                            rp_reg[cur]   <= (rp_reg[cur] == LAST_PTR) ? '0 : rp_reg[cur] + 1'b1;
                            fill_reg[cur] <= fill_reg[cur] - 1'b1;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end else if (mode != mpam_pkg::MODE_TONE) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SC_ACC: cnt_reg <= cnt_reg + 1'b1;
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    item_reg <= in_item;
                    acc_reg  <= 16'sd0;
                end
            end
            ST_SEL: begin
                tneg_reg <= kfull[B-1];
                // fold into the first quarter wave
                if (klow > B'(QUARTER)) begin
                    kq_reg <= KW'(B'(HALF) - klow);
                end else begin
                    kq_reg <= KW'(klow);
                end
            end
            ST_FIFO_RD: begin
                sneg_reg <= ram_rdata[15];
                smag_reg <= ram_rdata[15] ? neg_rd[15:0] : ram_rdata;
            end
            ST_SIN_SQ:  x_reg <= xs;
            ST_SIN_T: begin
                x2_reg   <= prod_reg[30 +: 32];
                term_reg <= x_reg;
                sum_reg  <= x_reg;
                i_reg    <= 3'd1;
            end
            ST_SIN_YR:  y_reg  <= prod_reg[30 +: 32];
            ST_SIN_QD:  q0_reg <= prod_reg[32 +: 32];
            ST_SIN_R: begin
                // reciprocal estimate is low by at most one
                term_reg <= (rem >= 32'(mpam_pkg::term_divisor(i_reg))) ? q0_reg + 32'd1
                                                                          : q0_reg;
            end
            ST_SIN_ACC: begin
                sum_reg <= i_reg[0] ? sum_reg - term_reg : sum_reg + term_reg;
                i_reg   <= i_reg + 3'd1;
            end
            ST_SIN_MAG: begin
                smag_reg <= amp_sum[30 +: 16];
                sneg_reg <= tneg_reg;
            end
            ST_SC_ACC:  acc_reg <= acc_sat;
            default: begin
            end
        endcase
    end

    a_ram_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("fifo write and read in the same cycle");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg[cur] <= FULL)
        else $error("fifo fill level above depth");

    a_push_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_item.push_ok |-> res_item.mixed_sample == 16'sd0)
        else $error("accepted push carries a nonzero mix");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in progress");

endmodule

`default_nettype wire

// File: rtl/multi_port_audio_mixer.sv
// Sequence: a push runs ST_IDLE, ST_PUSH, then the result stage; a tick runs ST_SEL for
//   each port, ST_FIFO_RD and scaling for each running fifo port with data, and the sine
//   states and scaling for each tone port (each sine runs 7 series terms, 3 shared multiplier passes apiece).
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: aresetn synchronous, active low; clears pointers, fill levels, tone phases and
//   frame position, and loads the config registers with their defaults. FIFO contents stay.
// ----------------------------------------------------------------------------
// Multi-port audio mixer
// Config registers, request intake and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_port_audio_mixer #(
    parameter int PORT_COUNT      = mpam_pkg::PORT_COUNT_DEF,
    parameter int FIFO_DEPTH      = mpam_pkg::FIFO_DEPTH_DEF,
    parameter int SINE_TABLE_BITS = mpam_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mpam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mpam_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire mpam_pkg::in_item_t                s_item,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output mpam_pkg::out_item_t                    m_item
);

    mpam_pkg::cfg_t      cfg_reg;
    logic                m_valid_reg;
    mpam_pkg::out_item_t m_item_reg;
    logic                res_valid, res_ready;
    mpam_pkg::out_item_t res_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.master_volume <= mpam_pkg::UNITY_Q15;
            cfg_reg.port_volume   <= {mpam_pkg::REG_PORTS{mpam_pkg::UNITY_Q15}};
            cfg_reg.port_modes    <= '0;
            cfg_reg.tone_step     <= mpam_pkg::STEP_RESET;
            cfg_reg.channel_count <= mpam_pkg::CHANNELS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mpam_pkg::REG_MASTER:   cfg_reg.master_volume  <= cfg_data[15:0];
                mpam_pkg::REG_VOL0:     cfg_reg.port_volume[0] <= cfg_data[15:0];
                mpam_pkg::REG_VOL1:     cfg_reg.port_volume[1] <= cfg_data[15:0];
                mpam_pkg::REG_VOL2:     cfg_reg.port_volume[2] <= cfg_data[15:0];
                mpam_pkg::REG_VOL3:     cfg_reg.port_volume[3] <= cfg_data[15:0];
                mpam_pkg::REG_MODES:    cfg_reg.port_modes     <= cfg_data[7:0];
                mpam_pkg::REG_STEP:     cfg_reg.tone_step      <= cfg_data[31:0];
                mpam_pkg::REG_CHANNELS: cfg_reg.channel_count  <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    mpam_core #(
        .PORT_COUNT     (PORT_COUNT),
        .FIFO_DEPTH     (FIFO_DEPTH),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (s_item),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_item (res_item)
    );

    // hold the result until the sink takes it
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire
